// ----- src/ddmc_pkg.sv -----
package ddmc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned CmdW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 14;

  // Input event kinds
  localparam logic [1:0] MODE_JOYSTICK = 2'd0;
  localparam logic [1:0] MODE_REMOTE   = 2'd1;
  localparam logic [1:0] MODE_ECHO     = 2'd2;

  // Remote command bytes, also used as classified motion codes
  localparam logic [CmdW-1:0] CMD_FWD      = 8'd10;
  localparam logic [CmdW-1:0] CMD_BACK     = 8'd5;
  localparam logic [CmdW-1:0] CMD_RIGHT    = 8'd8;
  localparam logic [CmdW-1:0] CMD_LEFT     = 8'd2;
  localparam logic [CmdW-1:0] CMD_STOP     = 8'd4;
  localparam logic [CmdW-1:0] CMD_JOYSTICK = 8'd50;

  // Motor pin codes
  localparam logic [1:0] PIN_IDLE  = 2'd0;
  localparam logic [1:0] PIN_BACK  = 2'd1;
  localparam logic [1:0] PIN_FWD   = 2'd2;
  localparam logic [1:0] PIN_BRAKE = 2'd3;

  // Potentiometer actions
  localparam logic [1:0] POT_NONE  = 2'd0;
  localparam logic [1:0] POT_PULSE = 2'd1;
  localparam logic [1:0] POT_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FWD_TH     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REV_TH     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_OFS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TURN_DUTY  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STOP_DUTY  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_COUNT = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_REMOTE_LVL = 3'd7;

  localparam logic [DutyW-1:0] DUTY_RESET = 14'd8000;

  typedef struct packed {
    logic [SampleW-1:0] forward_threshold;
    logic [SampleW-1:0] reverse_threshold;
    logic [DutyW-1:0]   duty_offset;
    logic [DutyW-1:0]   duty_gain;
    logic [DutyW-1:0]   turn_duty;
    logic [DutyW-1:0]   stop_duty;
    logic [DutyW-1:0]   near_count;
    logic [SampleW-1:0] remote_level;
  } ddmc_cfg_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SampleW-1:0] x_sample;
    logic [SampleW-1:0] y_sample;
    logic [CmdW-1:0]    command;
    logic [DutyW-1:0]   echo_count;
  } ddmc_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_a;
    logic [DutyW-1:0] duty_b;
    logic [1:0]       dir_a;
    logic [1:0]       dir_b;
    logic             fwd_enable;
    logic             remote;
    logic             near;
    logic             far;
  } ddmc_state_t;

endpackage

// ----- src/ddmc_step.sv -----
module ddmc_step import ddmc_pkg::*; (
  input  ddmc_cfg_t   cfg_i,
  input  ddmc_item_t  item_i,
  input  ddmc_state_t state_i,
  output ddmc_state_t state_o,
  output logic [1:0]  pot_o
);

  logic               move_en;
  logic [CmdW-1:0]    move_cmd;
  logic [SampleW-1:0] move_y;
  logic [SampleW:0]   mul_op;
  logic [SampleW+DutyW:0] prod;
  logic [DutyW:0]     dec;
  logic [DutyW-1:0]   duty_prop;

  always_comb begin
    move_en  = 1'b0;
    move_cmd = item_i.command;
    move_y   = item_i.y_sample;
    unique case (item_i.mode)
      MODE_JOYSTICK: begin
        move_en = !state_i.remote;
        if (item_i.y_sample > cfg_i.forward_threshold) begin
          move_cmd = CMD_FWD;
        end else if (item_i.y_sample < cfg_i.reverse_threshold) begin
          move_cmd = CMD_BACK;
        end else if (item_i.x_sample > cfg_i.forward_threshold) begin
          move_cmd = CMD_RIGHT;
        end else if (item_i.x_sample < cfg_i.reverse_threshold) begin
          move_cmd = CMD_LEFT;
        end else begin
          move_cmd = CMD_STOP;
        end
      end
      MODE_REMOTE: begin
        move_en = (item_i.command != CMD_JOYSTICK);
        move_y  = cfg_i.remote_level;
      end
      default: ;
    endcase
  end

  // Backward duty scales with the distance from full scale
  assign mul_op = (move_cmd == CMD_BACK) ? (13'd4096 - {1'b0, move_y}) : {1'b0, move_y};
  assign prod   = {{DutyW{1'b0}}, mul_op} * {{(SampleW+1){1'b0}}, cfg_i.duty_gain};
  assign dec    = prod[SampleW+DutyW:SampleW];
  assign duty_prop = (dec >= {1'b0, cfg_i.duty_offset}) ? '0
                   : (cfg_i.duty_offset - dec[DutyW-1:0]);

  always_comb begin
    state_o = state_i;
    pot_o   = POT_NONE;

    if (item_i.mode == MODE_REMOTE) begin
      state_o.remote = (item_i.command != CMD_JOYSTICK);
    end

    if (item_i.mode == MODE_ECHO) begin
      if (item_i.echo_count < cfg_i.near_count) begin
        pot_o = POT_PULSE;
        if (!state_i.near) begin
          state_o.fwd_enable = 1'b0;
          state_o.near       = 1'b1;
          state_o.far        = 1'b0;
        end
      end else if (!state_i.far) begin
        pot_o = POT_CLEAR;
        state_o.fwd_enable = 1'b1;
        state_o.near       = 1'b0;
        state_o.far        = 1'b1;
      end
    end

    if (move_en) begin
      case (move_cmd)
        CMD_FWD: begin
          state_o.duty_a = duty_prop;
          state_o.duty_b = duty_prop;
          state_o.dir_a  = PIN_FWD;
          state_o.dir_b  = PIN_FWD;
        end
        CMD_BACK: begin
          state_o.duty_a = duty_prop;
          state_o.duty_b = duty_prop;
          state_o.dir_a  = PIN_BACK;
          state_o.dir_b  = PIN_BACK;
        end
        CMD_RIGHT: begin
          state_o.duty_a = cfg_i.turn_duty;
          state_o.dir_a  = PIN_FWD;
          state_o.dir_b  = PIN_BRAKE;
        end
        CMD_LEFT: begin
          state_o.duty_b = cfg_i.turn_duty;
          state_o.dir_a  = PIN_BRAKE;
          state_o.dir_b  = PIN_FWD;
        end
        CMD_STOP: begin
          state_o.duty_a = cfg_i.stop_duty;
          state_o.duty_b = cfg_i.stop_duty;
          state_o.dir_a  = PIN_BRAKE;
          state_o.dir_b  = PIN_BRAKE;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/differential_drive_mode_controller.sv -----
// Two-wheel drive controller fed by joystick, remote and echo beats. Each input beat yields
// exactly one result beat carrying the motor duty and pin codes, the forward enable, the
// remote flag and the potentiometer action. A beat is captured in an input register, the
// state update (threshold compares, one 13x14 multiply and a clamped subtract) runs
// combinationally from that register, and the result lands in an output register; one
// beat is taken every cycle while the output side keeps up. Write the configuration
// registers only while no beats are in flight.
module differential_drive_mode_controller import ddmc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [SampleW-1:0] x_sample_i,
  input  logic [SampleW-1:0] y_sample_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [DutyW-1:0]   echo_count_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DutyW-1:0]   duty_a_o,
  output logic [DutyW-1:0]   duty_b_o,
  output logic [1:0]         dir_a_o,
  output logic [1:0]         dir_b_o,
  output logic               forward_enabled_o,
  output logic               in_remote_o,
  output logic [1:0]         pot_action_o
);

  ddmc_cfg_t   cfg_q;
  ddmc_item_t  item_q;
  logic        item_valid_q;
  ddmc_state_t state_q, state_d;
  logic [1:0]  pot_d;
  logic        advance;

  ddmc_state_t res_q;
  logic [1:0]  res_pot_q;
  logic        res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_threshold <= 12'd2234;
      cfg_q.reverse_threshold <= 12'd1862;
      cfg_q.duty_offset       <= 14'd11500;
      cfg_q.duty_gain         <= 14'd9900;
      cfg_q.turn_duty         <= 14'd6400;
      cfg_q.stop_duty         <= 14'd16000;
      cfg_q.near_count        <= 14'd1000;
      cfg_q.remote_level      <= 12'd2358;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FWD_TH:     cfg_q.forward_threshold <= cfg_data_i[SampleW-1:0];
        CFG_REV_TH:     cfg_q.reverse_threshold <= cfg_data_i[SampleW-1:0];
        CFG_DUTY_OFS:   cfg_q.duty_offset       <= cfg_data_i;
        CFG_DUTY_GAIN:  cfg_q.duty_gain         <= cfg_data_i;
        CFG_TURN_DUTY:  cfg_q.turn_duty         <= cfg_data_i;
        CFG_STOP_DUTY:  cfg_q.stop_duty         <= cfg_data_i;
        CFG_NEAR_COUNT: cfg_q.near_count        <= cfg_data_i;
        CFG_REMOTE_LVL: cfg_q.remote_level      <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Process the held beat once the result register is free or draining
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.mode       <= mode_i;
      item_q.x_sample   <= x_sample_i;
      item_q.y_sample   <= y_sample_i;
      item_q.command    <= command_i;
      item_q.echo_count <= echo_count_i;
    end
  end

  ddmc_step u_step (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .pot_o   (pot_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.duty_a     <= DUTY_RESET;
      state_q.duty_b     <= DUTY_RESET;
      state_q.dir_a      <= PIN_IDLE;
      state_q.dir_b      <= PIN_IDLE;
      state_q.fwd_enable <= 1'b1;
      state_q.remote     <= 1'b0;
      state_q.near       <= 1'b0;
      state_q.far        <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q     <= state_d;
      res_pot_q <= pot_d;
    end
  end

  assign out_valid_o       = res_valid_q;
  assign duty_a_o          = res_q.duty_a;
  assign duty_b_o          = res_q.duty_b;
  assign dir_a_o           = res_q.dir_a;
  assign dir_b_o           = res_q.dir_b;
  assign forward_enabled_o = res_q.fwd_enable;
  assign in_remote_o       = res_q.remote;
  assign pot_action_o      = res_pot_q;

  a_latch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.near && state_q.far))
    else $error("near and far latches both set");

  a_pulse_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pot_action_o == POT_PULSE |-> !forward_enabled_o)
    else $error("pot pulse while forward pins enabled");

  a_clear_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pot_action_o == POT_CLEAR |-> forward_enabled_o)
    else $error("pot clear while forward pins masked");

  a_pot_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pot_action_o != 2'd3)
    else $error("undefined pot action");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid_q && res_valid_q && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule
